### design/seam_linear_blend_top_macros.svh
// Assertion macros for the seam blend top-level design file.
`ifndef SEAM_LINEAR_BLEND_TOP_MACROS_SVH
`define SEAM_LINEAR_BLEND_TOP_MACROS_SVH

`ifndef SYNTH
`define SLB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("seam_linear_blend assertion failed");
`define SLB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("seam_linear_blend assertion failed");
`else
`define SLB_ASSERT(label, clk, rst_n, prop)
`define SLB_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### design/seam_lb_pkg.sv
package seam_lb_pkg;

    localparam int unsigned ColW       = 13;
    localparam int unsigned PixW       = 8;
    localparam int unsigned NumChan    = 3;
    localparam int unsigned NumW       = ColW + PixW;
    localparam int unsigned QuoW       = PixW;
    localparam int unsigned LaneLat    = 2 + QuoW;
    localparam int unsigned MaxColumns = 8192;
    localparam int unsigned InTdataW   = 64;
    localparam int unsigned OutTdataW  = 24;
    localparam int unsigned CfgIdxW    = 2;

    localparam logic [CfgIdxW-1:0] CfgBandStart = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgBandEnd   = 2'd1;

    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [QuoW-1:0] quo;
        logic [ColW-1:0] divisor;
        logic [PixW-1:0] base;
        logic            keep_base;
    } t_div_word;

endpackage

### design/seam_lb_div_step.sv
module seam_lb_div_step #(
    parameter int unsigned Shift = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  seam_lb_pkg::t_div_word i_word,
    output seam_lb_pkg::t_div_word o_word
);

    logic [seam_lb_pkg::NumW-1:0] trial;
    logic                         take;
    seam_lb_pkg::t_div_word       n_word;
    seam_lb_pkg::t_div_word       r_word;

    assign trial = seam_lb_pkg::NumW'(i_word.divisor) << Shift;
    assign take  = i_word.rem >= trial;

    always_comb begin
        n_word = i_word;
        if (take) begin
            n_word.rem        = i_word.rem - trial;
            n_word.quo[Shift] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### design/seam_lb_lane.sv
module seam_lb_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_inside,
    input  logic [seam_lb_pkg::ColW-1:0] i_span,
    input  logic [seam_lb_pkg::ColW-1:0] i_left,
    input  logic [seam_lb_pkg::ColW-1:0] i_offset,
    input  logic [seam_lb_pkg::PixW-1:0] i_base,
    input  logic [seam_lb_pkg::PixW-1:0] i_warp,
    output logic [seam_lb_pkg::PixW-1:0] o_pix
);

    logic [seam_lb_pkg::NumW-1:0] r_prod_base;
    logic [seam_lb_pkg::NumW-1:0] r_prod_warp;
    logic [seam_lb_pkg::ColW-1:0] r_span;
    logic [seam_lb_pkg::PixW-1:0] r_base;
    logic                         r_keep;
    seam_lb_pkg::t_div_word       r_sum;
    seam_lb_pkg::t_div_word       chain [0:seam_lb_pkg::QuoW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_base <= seam_lb_pkg::NumW'(i_base) * seam_lb_pkg::NumW'(i_left);
            r_prod_warp <= seam_lb_pkg::NumW'(i_warp) * seam_lb_pkg::NumW'(i_offset);
            r_span      <= i_span;
            r_base      <= i_base;
            r_keep      <= !i_inside || (i_warp == '0);

            r_sum.rem       <= seam_lb_pkg::NumW'({1'b0, r_prod_base} + {1'b0, r_prod_warp});
            r_sum.quo       <= '0;
            r_sum.divisor   <= r_span;
            r_sum.base      <= r_base;
            r_sum.keep_base <= r_keep;
        end
    end

    assign chain[0] = r_sum;

    for (genvar g = 0; g < seam_lb_pkg::QuoW; g++) begin : g_step
        seam_lb_div_step #(
            .Shift(seam_lb_pkg::QuoW - 1 - g)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_word(chain[g]),
            .o_word(chain[g+1])
        );
    end

    assign o_pix = chain[seam_lb_pkg::QuoW].keep_base ? chain[seam_lb_pkg::QuoW].base
                                                      : chain[seam_lb_pkg::QuoW].quo;

endmodule

### design/seam_linear_blend_top.sv
// Linear feather blend of a base and a warped RGB pixel stream across a column band.
// Input words arrive on s_axis: tdata holds column, three base channels and three
// warped channels. Output words leave on m_axis: tdata holds the three blended
// channels and tuser flags a pixel that lay inside the band.
// The band is set through the configuration channel (index 0 start, index 1 end);
// it is always ready, and the user must write it only while no pixel is in flight;
// the block does not enforce this. Throughput is one pixel per clock when not stalled.
// A pixel passes the input register, which loads at the accepting edge, then two
// multiply and sum stages, eight restoring divider stages (one quotient bit each,
// one per channel lane) and the output register. The divider chain length sets the latency.
// Reset clears the band to empty and drops all words in flight.
// When the receiver stalls, one more word lands in a skid register and s_axis_tready
// falls the next cycle; the whole pipeline holds until the skid register drains.
`include "seam_linear_blend_top_macros.svh"

module seam_linear_blend_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // column[12:0], dst_c0, dst_c1, dst_c2, warp_c0, warp_c1, warp_c2, zero fill
    input  logic [seam_lb_pkg::InTdataW-1:0]       s_axis_tdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // out_c0[7:0], out_c1[15:8], out_c2[23:16]
    output logic [seam_lb_pkg::OutTdataW-1:0]      m_axis_tdata,
    // in_band
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [seam_lb_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [seam_lb_pkg::ColW-1:0]           i_cfg_data
);

    localparam int unsigned ColW    = seam_lb_pkg::ColW;
    localparam int unsigned PixW    = seam_lb_pkg::PixW;
    localparam int unsigned NumChan = seam_lb_pkg::NumChan;
    localparam int unsigned LaneLat = seam_lb_pkg::LaneLat;

    logic [ColW-1:0]      r_band_start;
    logic [ColW-1:0]      r_band_end;

    logic                 en;
    logic [ColW-1:0]      column;
    logic [PixW-1:0]      dst  [NumChan];
    logic [PixW-1:0]      warp [NumChan];
    logic                 n_inside;

    logic                 r_s0_valid;
    logic                 r_s0_inside;
    logic [ColW-1:0]      r_s0_span;
    logic [ColW-1:0]      r_s0_left;
    logic [ColW-1:0]      r_s0_offset;
    logic [PixW-1:0]      r_s0_base [NumChan];
    logic [PixW-1:0]      r_s0_warp [NumChan];

    logic [LaneLat-1:0]   r_vld;
    logic [LaneLat-1:0]   r_ins;
    logic [PixW-1:0]      lane_pix [NumChan];

    logic                              p_valid;
    logic [seam_lb_pkg::OutTdataW-1:0] p_data;
    logic                              p_user;
    logic                              out_free;

    logic                              r_out_valid;
    logic [seam_lb_pkg::OutTdataW-1:0] r_out_data;
    logic                              r_out_user;
    logic                              r_skid_valid;
    logic [seam_lb_pkg::OutTdataW-1:0] r_skid_data;
    logic                              r_skid_user;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_start <= '0;
            r_band_end   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                seam_lb_pkg::CfgBandStart: r_band_start <= i_cfg_data;
                seam_lb_pkg::CfgBandEnd:   r_band_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    assign column = s_axis_tdata[ColW-1:0];
    for (genvar c = 0; c < NumChan; c++) begin : g_unpack
        assign dst[c]  = s_axis_tdata[ColW + c*PixW +: PixW];
        assign warp[c] = s_axis_tdata[ColW + (NumChan + c)*PixW +: PixW];
    end

    assign n_inside = (r_band_end > r_band_start) && (column >= r_band_start)
                      && (column < r_band_end) && (32'(column) < seam_lb_pkg::MaxColumns);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_vld      <= '0;
        end else if (en) begin
            r_s0_valid <= s_axis_tvalid;
            r_vld      <= {r_vld[LaneLat-2:0], r_s0_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_inside <= n_inside;
            r_s0_span   <= r_band_end - r_band_start;
            r_s0_left   <= r_band_end - column;
            r_s0_offset <= column - r_band_start;
            r_s0_base   <= dst;
            r_s0_warp   <= warp;
            r_ins       <= {r_ins[LaneLat-2:0], r_s0_inside};
        end
    end

    for (genvar c = 0; c < NumChan; c++) begin : g_lane
        seam_lb_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_inside(r_s0_inside),
            .i_span  (r_s0_span),
            .i_left  (r_s0_left),
            .i_offset(r_s0_offset),
            .i_base  (r_s0_base[c]),
            .i_warp  (r_s0_warp[c]),
            .o_pix   (lane_pix[c])
        );
    end

    assign p_valid  = r_vld[LaneLat-1];
    assign p_user   = r_ins[LaneLat-1];
    assign p_data   = {lane_pix[2], lane_pix[1], lane_pix[0]};
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= en && p_valid;
            end
        end else if (en && p_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else begin
                r_out_data <= p_data;
                r_out_user <= p_user;
            end
        end else if (en) begin
            r_skid_data <= p_data;
            r_skid_user <= p_user;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `SLB_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `SLB_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(!out_free))
    `SLB_ASSERT(a_line_frozen, i_clk, i_rst_n, !s_axis_tready |=> $stable(r_vld))
    `SLB_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid && !r_skid_valid)

endmodule

### test/seam_blend_checker.sv
`timescale 1ns / 100ps

module seam_blend_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [seam_lb_pkg::InTdataW-1:0]    s_axis_tdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [seam_lb_pkg::OutTdataW-1:0]   m_axis_tdata,
    input  logic                                m_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [seam_lb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [seam_lb_pkg::ColW-1:0]        i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int PendDepth = 64;

    typedef struct packed {
        logic                                                   in_band;
        logic [seam_lb_pkg::NumChan-1:0][seam_lb_pkg::PixW-1:0] chan;
    } t_blended;

    logic [seam_lb_pkg::ColW-1:0] band_start_q = '0;
    logic [seam_lb_pkg::ColW-1:0] band_end_q   = '0;
    t_blended                     expected_pixels [PendDepth];
    int                           wr_count = 0;
    int                           rd_count = 0;
    int                           fails    = 0;

    function automatic t_blended blend_pixel(input logic [seam_lb_pkg::InTdataW-1:0] word);
        logic [seam_lb_pkg::ColW-1:0] col;
        logic [seam_lb_pkg::PixW-1:0] base;
        logic [seam_lb_pkg::PixW-1:0] warp;
        int unsigned                  width;
        int unsigned                  offset;
        t_blended                     res;
        col         = word[seam_lb_pkg::ColW-1:0];
        res.in_band = (band_end_q > band_start_q) && (col >= band_start_q)
                      && (col < band_end_q) && (col < seam_lb_pkg::MaxColumns);
        width       = 32'(band_end_q) - 32'(band_start_q);
        offset      = 32'(col) - 32'(band_start_q);
        for (int c = 0; c < seam_lb_pkg::NumChan; c++) begin
            base = word[seam_lb_pkg::ColW + c*seam_lb_pkg::PixW +: seam_lb_pkg::PixW];
            warp = word[seam_lb_pkg::ColW + (seam_lb_pkg::NumChan + c)*seam_lb_pkg::PixW
                        +: seam_lb_pkg::PixW];
            if (!res.in_band || warp == '0) begin
                res.chan[c] = base;
            end else begin
                res.chan[c] = seam_lb_pkg::PixW'((base * (width - offset) + warp * offset)
                                                 / width);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_blended want;
        if (!i_rst_n) begin
            band_start_q = '0;
            band_end_q   = '0;
            wr_count     = 0;
            rd_count     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    seam_lb_pkg::CfgBandStart: band_start_q = i_cfg_data;
                    seam_lb_pkg::CfgBandEnd:   band_end_q   = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (wr_count == rd_count) begin
                    $display("%0t: output word with no pixel waiting, tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    fails++;
                end else begin
                    want = expected_pixels[rd_count % PendDepth];
                    rd_count++;
                    for (int c = 0; c < seam_lb_pkg::NumChan; c++) begin
                        if (m_axis_tdata[c*seam_lb_pkg::PixW +: seam_lb_pkg::PixW]
                            !== want.chan[c]) begin
                            $display("%0t: out_c%0d mismatch, expected %0d, actual %0d",
                                     $time, c, want.chan[c],
                                     m_axis_tdata[c*seam_lb_pkg::PixW +: seam_lb_pkg::PixW]);
                            fails++;
                        end
                    end
                    if (m_axis_tuser !== want.in_band) begin
                        $display("%0t: in_band mismatch, expected %b, actual %b",
                                 $time, want.in_band, m_axis_tuser);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pixels[wr_count % PendDepth] = blend_pixel(s_axis_tdata);
                wr_count++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= wr_count - rd_count;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [seam_lb_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
    localparam logic [seam_lb_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;
    localparam int ColMax        = seam_lb_pkg::MaxColumns - 1;
    localparam int NumSegments   = 10;
    localparam int SegmentItems  = 45;
    localparam int DrainCycles   = 24;
    localparam int LongStall     = 80;
    localparam int WatchdogLimit = 2000;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic [seam_lb_pkg::InTdataW-1:0]   s_axis_tdata  = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [seam_lb_pkg::OutTdataW-1:0]  m_axis_tdata;
    logic                               m_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic                               i_cfg_valid   = 1'b0;
    logic                               o_cfg_ready;
    logic [seam_lb_pkg::CfgIdxW-1:0]    i_cfg_index   = '0;
    logic [seam_lb_pkg::ColW-1:0]       i_cfg_data    = '0;

    int   fail_count;
    int   pending;
    int   src_idle_pct    = 16;
    int   sink_idle_pct   = 55;
    int   band_lo         = 0;
    int   band_hi         = 0;
    logic long_stall_req  = 1'b0;
    logic long_stall_done = 1'b0;
    int   long_stall_left = 0;
    int   idle_cycles     = 0;

    seam_linear_blend_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    seam_blend_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (long_stall_left > 0) begin
            m_axis_tready   <= 1'b0;
            long_stall_left <= long_stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            m_axis_tready   <= 1'b0;
            long_stall_left <= LongStall;
            long_stall_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("FAIL seam_linear_blend_top");
            $finish;
        end
    end

    // Base and warp carry channel 0 in their lowest byte.
    task automatic send_pixel(input logic [seam_lb_pkg::ColW-1:0] col,
                              input logic [23:0] base, input logic [23:0] warp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seam_lb_pkg::InTdataW'({warp, base, col});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [seam_lb_pkg::PixW-1:0] rand_level(input int zero_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < zero_pct) return '0;
        if (pick < zero_pct + 8) return '1;
        return seam_lb_pkg::PixW'($urandom_range(255));
    endfunction

    task automatic send_random_pixel();
        int                           lo;
        int                           hi;
        logic [seam_lb_pkg::ColW-1:0] col;
        logic [23:0]                  base;
        logic [23:0]                  warp;
        if ($urandom_range(99) < 70) begin
            lo  = (band_lo > 2) ? band_lo - 2 : 0;
            hi  = (band_hi + 2 > ColMax) ? ColMax : band_hi + 2;
            col = seam_lb_pkg::ColW'($urandom_range(hi, lo));
        end else begin
            col = seam_lb_pkg::ColW'($urandom);
        end
        for (int c = 0; c < seam_lb_pkg::NumChan; c++) begin
            base[c*seam_lb_pkg::PixW +: seam_lb_pkg::PixW] = rand_level(3);
            warp[c*seam_lb_pkg::PixW +: seam_lb_pkg::PixW] = rand_level(20);
        end
        send_pixel(col, base, warp);
    endtask

    // The caller lowers i_cfg_valid once the last write of a batch is taken.
    task automatic write_reg(input logic [seam_lb_pkg::CfgIdxW-1:0] idx,
                             input logic [seam_lb_pkg::ColW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_band(input int start_col, input int end_col);
        drain();
        write_reg(seam_lb_pkg::CfgBandStart, seam_lb_pkg::ColW'(start_col));
        write_reg(seam_lb_pkg::CfgBandEnd, seam_lb_pkg::ColW'(end_col));
        i_cfg_valid <= 1'b0;
        band_lo = start_col;
        band_hi = end_col;
    endtask

    initial begin
        int start_col;
        int end_col;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty band straight out of reset, then writes to unused indexes.
        send_pixel(13'd0, 24'h000000, 24'hFFFFFF);
        send_pixel(13'h1FFF, 24'hFFFFFF, 24'h010203);
        drain();
        write_reg(CfgSpareLo, 13'h1FFF);
        write_reg(CfgSpareHi, 13'h0AAA);
        i_cfg_valid <= 1'b0;
        send_pixel(13'd5, 24'h123456, 24'hABCDEF);

        set_band(100, 356);
        send_pixel(13'd99, 24'h102030, 24'hF0E0D0);
        send_pixel(13'd100, 24'h102030, 24'hF0E0D0);
        send_pixel(13'd101, 24'hFFFFFF, 24'h010101);
        send_pixel(13'd228, 24'h00FF80, 24'h00FF80);
        send_pixel(13'd355, 24'h000000, 24'hFFFFFF);
        send_pixel(13'd356, 24'h445566, 24'hFFFFFF);

        set_band(8190, 8191);
        send_pixel(13'd8189, 24'h808080, 24'h7F7F7F);
        send_pixel(13'd8190, 24'hFF00FF, 24'h00FF01);
        send_pixel(13'd8191, 24'hFF00FF, 24'h00FF01);

        set_band(8191, 0);
        send_pixel(13'd8191, 24'hAA55AA, 24'h55AA55);
        send_pixel(13'd0, 24'hAA55AA, 24'h55AA55);

        set_band(50, 50);
        send_pixel(13'd50, 24'h0F0F0F, 24'hF0F0F0);

        set_band(0, 8191);
        send_pixel(13'd0, 24'h000000, 24'hFFFFFF);
        send_pixel(13'd1, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(13'd4095, 24'hFF0000, 24'h00FFFF);
        send_pixel(13'd8190, 24'h000000, 24'hFFFFFF);
        send_pixel(13'd8191, 24'h000000, 24'hFFFFFF);

        for (int seg = 0; seg < NumSegments; seg++) begin
            case (seg)
                0: begin
                    start_col = 0;
                    end_col   = ColMax;
                end
                1: begin
                    start_col = ColMax - 1;
                    end_col   = ColMax;
                end
                2: begin
                    start_col = $urandom_range(ColMax, 4096);
                    end_col   = $urandom_range(4095);
                end
                3: begin
                    start_col = $urandom_range(ColMax);
                    end_col   = start_col;
                end
                default: begin
                    start_col = $urandom_range(ColMax);
                    end_col   = start_col + (($urandom_range(3) == 0) ?
                                $urandom_range(ColMax) : $urandom_range(64, 1));
                    if (end_col > ColMax) end_col = ColMax;
                end
            endcase
            set_band(start_col, end_col);
            if (seg < 3) begin
                src_idle_pct  = 16;
                sink_idle_pct = 55;
            end else if (seg < 7) begin
                src_idle_pct  = 55;
                sink_idle_pct = 16;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (seg == 8) begin
                long_stall_req <= 1'b1;
            end
            repeat (SegmentItems) send_random_pixel();
        end

        drain();
        if (fail_count == 0) begin
            $display("PASS seam_linear_blend_top");
        end else begin
            $display("FAIL seam_linear_blend_top");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/seam_lb_pkg.sv
design/seam_lb_div_step.sv
design/seam_lb_lane.sv
design/seam_linear_blend_top.sv
test/seam_blend_checker.sv
test/testbench.sv
